// ===== hw/rtl/homography_pixel_source_mapper_top_macros.svh =====
// Assertion macros shared by the homography source mapper RTL.
`ifndef HOMOGRAPHY_PIXEL_SOURCE_MAPPER_TOP_MACROS_SVH
`define HOMOGRAPHY_PIXEL_SOURCE_MAPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion with an explicit clock and active-low reset.
`define HPSM_ASSERT_CLK(lbl, clk_i, rst_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_i) prop) else $error("assertion failed");
// Clocked assertion on the module's own clk and rst_n.
`define HPSM_ASSERT(lbl, prop) `HPSM_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define HPSM_ASSERT_CLK(lbl, clk_i, rst_i, prop)
`define HPSM_ASSERT(lbl, prop)
`endif
`endif

// ===== hw/rtl/hpsm_pkg.sv =====
// Package with types and constants of the homography source mapper.
package hpsm_pkg;

    // Quotient bits resolved by the divider pipeline.
    localparam int QBITS = 30;
    // Divisor width (positive divisor below 2^46).
    localparam int DW = 46;
    // Remainder width of the divider.
    localparam int RW = 77;
    // Signed width of the numerator and divisor sums.
    localparam int SW = 47;
    // Signed width of one coefficient by coordinate product.
    localparam int PW = 45;

    localparam logic signed [SW-1:0] Q_ONE = 47'sd65536;
    localparam logic signed [31:0] Q_HALF = 32'sd32768;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_SCALE_XX = 4'd0,
        REG_SHEAR_XY = 4'd1,
        REG_OFFSET_X = 4'd2,
        REG_SHEAR_YX = 4'd3,
        REG_SCALE_YY = 4'd4,
        REG_OFFSET_Y = 4'd5,
        REG_PERSP_X  = 4'd6,
        REG_PERSP_Y  = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] dst_col;
        logic [11:0] dst_row;
    } req_t;

    typedef struct packed {
        logic [10:0] src_col;
        logic [10:0] src_row;
        logic        inside_res;
        logic        chroma_site;
    } rsp_t;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic ok_x;
        logic ok_y;
        logic neg_x;
        logic neg_y;
        logic chroma;
    } div_meta_t;

endpackage

// ===== hw/rtl/hpsm_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
interface hpsm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hpsm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module hpsm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  hpsm_pkg::div_meta_t       in_meta,
    input  logic [hpsm_pkg::RW-1:0]   in_rem_x,
    input  logic [hpsm_pkg::RW-1:0]   in_rem_y,
    input  logic [hpsm_pkg::DW-1:0]   in_den,
    output logic                      out_valid,
    output hpsm_pkg::div_meta_t       out_meta,
    output logic [hpsm_pkg::QBITS-1:0] out_quo_x,
    output logic [hpsm_pkg::QBITS-1:0] out_quo_y
);

    localparam int NQ = hpsm_pkg::QBITS;

    logic                      valid_reg [1:NQ];
    hpsm_pkg::div_meta_t       meta_reg  [1:NQ];
    logic [hpsm_pkg::RW-1:0]   rem_x_reg [1:NQ];
    logic [hpsm_pkg::RW-1:0]   rem_y_reg [1:NQ];
    logic [hpsm_pkg::DW-1:0]   den_reg   [1:NQ];
    logic [NQ-1:0]             quo_x_reg [1:NQ];
    logic [NQ-1:0]             quo_y_reg [1:NQ];

    // Stage views, index zero being the pipeline input.
    logic                      valid_s [0:NQ];
    hpsm_pkg::div_meta_t       meta_s  [0:NQ];
    logic [hpsm_pkg::RW-1:0]   rem_x_s [0:NQ];
    logic [hpsm_pkg::RW-1:0]   rem_y_s [0:NQ];
    logic [hpsm_pkg::DW-1:0]   den_s   [0:NQ];
    logic [NQ-1:0]             quo_x_s [0:NQ];
    logic [NQ-1:0]             quo_y_s [0:NQ];

    assign valid_s[0] = in_valid;
    assign meta_s[0]  = in_meta;
    assign rem_x_s[0] = in_rem_x;
    assign rem_y_s[0] = in_rem_y;
    assign den_s[0]   = in_den;
    assign quo_x_s[0] = '0;
    assign quo_y_s[0] = '0;

    genvar k;
    generate
        for (k = 1; k <= NQ; k++)
        begin : g_stage
            logic [hpsm_pkg::RW-1:0] dsh;
            logic [hpsm_pkg::RW:0]   dif_x;
            logic [hpsm_pkg::RW:0]   dif_y;
            logic                    bit_x;
            logic                    bit_y;
            logic [hpsm_pkg::RW-1:0] rem_x_next;
            logic [hpsm_pkg::RW-1:0] rem_y_next;

            // Trial subtraction of the divisor aligned to this quotient bit.
            assign dsh   = hpsm_pkg::RW'(den_s[k-1]) << (NQ - k);
            assign dif_x = {1'b0, rem_x_s[k-1]} - {1'b0, dsh};
            assign dif_y = {1'b0, rem_y_s[k-1]} - {1'b0, dsh};
            assign bit_x = ~dif_x[hpsm_pkg::RW];
            assign bit_y = ~dif_y[hpsm_pkg::RW];
            assign rem_x_next = bit_x ? dif_x[hpsm_pkg::RW-1:0] : rem_x_s[k-1];
            assign rem_y_next = bit_y ? dif_y[hpsm_pkg::RW-1:0] : rem_y_s[k-1];

            // Stage valid bit.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= valid_s[k-1];
                end
            end

            // Stage payload.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    meta_reg[k]  <= meta_s[k-1];
                    rem_x_reg[k] <= rem_x_next;
                    rem_y_reg[k] <= rem_y_next;
                    den_reg[k]   <= den_s[k-1];
                    quo_x_reg[k] <= {quo_x_s[k-1][NQ-2:0], bit_x};
                    quo_y_reg[k] <= {quo_y_s[k-1][NQ-2:0], bit_y};
                end
            end

            assign valid_s[k] = valid_reg[k];
            assign meta_s[k]  = meta_reg[k];
            assign rem_x_s[k] = rem_x_reg[k];
            assign rem_y_s[k] = rem_y_reg[k];
            assign den_s[k]   = den_reg[k];
            assign quo_x_s[k] = quo_x_reg[k];
            assign quo_y_s[k] = quo_y_reg[k];
        end
    endgenerate

    assign out_valid = valid_s[NQ];
    assign out_meta  = meta_s[NQ];
    assign out_quo_x = quo_x_s[NQ];
    assign out_quo_y = quo_y_s[NQ];

endmodule

// ===== hw/rtl/homography_pixel_source_mapper_top.sv =====
// Top level of the homography source mapper: destination pixel in, source pixel out.
//
// Each destination pixel is mapped through the programmed homography to the
// nearest source pixel. One transaction is taken per clock unless the pipeline
// holds, and each result passes through one multiply stage, one sum stage, one
// stage that takes magnitudes and screens out non-positive divisors and
// out-of-range quotients, 30 stages of a restoring divider that resolves one
// quotient bit per stage, and the rounding stage that drives the output register.
// The whole pipeline holds while a result waits on a low rsp.ready. The user must
// write registers only while no transaction is in flight; the block does not enforce it.
`include "homography_pixel_source_mapper_top_macros.svh"

module homography_pixel_source_mapper_top #(
    parameter int SRC_WIDTH  = 2048,
    parameter int SRC_HEIGHT = 2048,
    parameter int DST_WIDTH  = 4096,
    parameter int DST_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_idx,
    input  logic [31:0]         cfg_data,
    hpsm_stream_if.sink         req,
    hpsm_stream_if.source       rsp
);

    localparam int PW = hpsm_pkg::PW;
    localparam int SW = hpsm_pkg::SW;

    // Matrix registers.
    logic signed [31:0] scale_xx_reg, shear_xy_reg, offset_x_reg;
    logic signed [31:0] shear_yx_reg, scale_yy_reg, offset_y_reg;
    logic signed [31:0] persp_x_reg, persp_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_xx_reg <= 32'sd65536;
            shear_xy_reg <= '0;
            offset_x_reg <= '0;
            shear_yx_reg <= '0;
            scale_yy_reg <= 32'sd65536;
            offset_y_reg <= '0;
            persp_x_reg  <= '0;
            persp_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (hpsm_pkg::reg_idx_t'(cfg_idx))
                hpsm_pkg::REG_SCALE_XX: scale_xx_reg <= cfg_data;
                hpsm_pkg::REG_SHEAR_XY: shear_xy_reg <= cfg_data;
                hpsm_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                hpsm_pkg::REG_SHEAR_YX: shear_yx_reg <= cfg_data;
                hpsm_pkg::REG_SCALE_YY: scale_yy_reg <= cfg_data;
                hpsm_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                hpsm_pkg::REG_PERSP_X:  persp_x_reg  <= cfg_data;
                hpsm_pkg::REG_PERSP_Y:  persp_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless a result is held at the output.
    logic         en;
    logic         rsp_valid_reg;
    hpsm_pkg::rsp_t rsp_data_reg;

    assign en        = ~rsp_valid_reg | rsp.ready;
    assign req.ready = en;

    // Stage 1: coefficient by coordinate products.
    logic signed [12:0] col_s, row_s;
    logic               s1_valid_reg, s1_frame_reg, s1_chroma_reg;
    logic signed [PW-1:0] s1_pxc_reg, s1_pxr_reg, s1_pyc_reg;
    logic signed [PW-1:0] s1_pyr_reg, s1_pdc_reg, s1_pdr_reg;
    logic               frame_next;

    assign col_s = $signed({1'b0, req.data.dst_col});
    assign row_s = $signed({1'b0, req.data.dst_row});
    assign frame_next = ({2'b0, req.data.dst_col} < 14'(DST_WIDTH))
                      && ({2'b0, req.data.dst_row} < 14'(DST_HEIGHT));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pxc_reg    <= PW'(scale_xx_reg) * PW'(col_s);
            s1_pxr_reg    <= PW'(shear_xy_reg) * PW'(row_s);
            s1_pyc_reg    <= PW'(shear_yx_reg) * PW'(col_s);
            s1_pyr_reg    <= PW'(scale_yy_reg) * PW'(row_s);
            s1_pdc_reg    <= PW'(persp_x_reg) * PW'(col_s);
            s1_pdr_reg    <= PW'(persp_y_reg) * PW'(row_s);
            s1_frame_reg  <= frame_next;
            s1_chroma_reg <= ~req.data.dst_col[0] & ~req.data.dst_row[0];
        end
    end

    // Stage 2: numerator and divisor sums.
    logic                 s2_valid_reg, s2_frame_reg, s2_chroma_reg;
    logic signed [SW-1:0] s2_nx_reg, s2_ny_reg, s2_den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_nx_reg     <= SW'(s1_pxc_reg) + SW'(s1_pxr_reg) + SW'(offset_x_reg);
            s2_ny_reg     <= SW'(s1_pyc_reg) + SW'(s1_pyr_reg) + SW'(offset_y_reg);
            s2_den_reg    <= SW'(s1_pdc_reg) + SW'(s1_pdr_reg) + hpsm_pkg::Q_ONE;
            s2_frame_reg  <= s1_frame_reg;
            s2_chroma_reg <= s1_chroma_reg;
        end
    end

    // Stage 3: magnitudes, divisor check and quotient range screen.
    logic [SW-1:0]           abs_x, abs_y;
    logic                    den_pos, ovf_x, ovf_y;
    logic [59:0]             den_lim;
    hpsm_pkg::div_meta_t     meta_next;
    logic                    s3_valid_reg;
    hpsm_pkg::div_meta_t     s3_meta_reg;
    logic [hpsm_pkg::RW-1:0] s3_rem_x_reg, s3_rem_y_reg;
    logic [hpsm_pkg::DW-1:0] s3_den_reg;

    assign abs_x   = s2_nx_reg[SW-1] ? SW'(-s2_nx_reg) : SW'(s2_nx_reg);
    assign abs_y   = s2_ny_reg[SW-1] ? SW'(-s2_ny_reg) : SW'(s2_ny_reg);
    assign den_pos = ~s2_den_reg[SW-1] & (|s2_den_reg);
    assign den_lim = {s2_den_reg[hpsm_pkg::DW-1:0], 14'b0};
    assign ovf_x   = 60'(abs_x) >= den_lim;
    assign ovf_y   = 60'(abs_y) >= den_lim;

    always_comb
    begin
        meta_next.ok_x   = s2_frame_reg & den_pos & ~ovf_x;
        meta_next.ok_y   = s2_frame_reg & den_pos & ~ovf_y;
        meta_next.neg_x  = s2_nx_reg[SW-1];
        meta_next.neg_y  = s2_ny_reg[SW-1];
        meta_next.chroma = s2_chroma_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_meta_reg  <= meta_next;
            s3_rem_x_reg <= hpsm_pkg::RW'({abs_x, 16'b0});
            s3_rem_y_reg <= hpsm_pkg::RW'({abs_y, 16'b0});
            s3_den_reg   <= s2_den_reg[hpsm_pkg::DW-1:0];
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Divider pipeline.
    logic                         d_valid;
    hpsm_pkg::div_meta_t          d_meta;
    logic [hpsm_pkg::QBITS-1:0]   d_quo_x, d_quo_y;

    hpsm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_meta   (s3_meta_reg),
        .in_rem_x  (s3_rem_x_reg),
        .in_rem_y  (s3_rem_y_reg),
        .in_den    (s3_den_reg),
        .out_valid (d_valid),
        .out_meta  (d_meta),
        .out_quo_x (d_quo_x),
        .out_quo_y (d_quo_y)
    );

    // Rounding: add one half, truncate toward zero, then range check.
    logic signed [31:0] qs_x, qs_y, t_x, t_y;
    logic               in_x, in_y, in_src;
    logic [10:0]        xx, yy;
    hpsm_pkg::rsp_t     rsp_data_next;

    assign qs_x = d_meta.neg_x ? -$signed({2'b0, d_quo_x}) : $signed({2'b0, d_quo_x});
    assign qs_y = d_meta.neg_y ? -$signed({2'b0, d_quo_y}) : $signed({2'b0, d_quo_y});
    assign t_x  = qs_x + hpsm_pkg::Q_HALF;
    assign t_y  = qs_y + hpsm_pkg::Q_HALF;
    assign in_x = d_meta.ok_x & (t_x[31] ? (t_x > -32'sd65536)
                                         : (t_x[31:16] < 16'(SRC_WIDTH)));
    assign in_y = d_meta.ok_y & (t_y[31] ? (t_y > -32'sd65536)
                                         : (t_y[31:16] < 16'(SRC_HEIGHT)));
    assign in_src = in_x & in_y;
    assign xx = t_x[31] ? 11'd0 : t_x[26:16];
    assign yy = t_y[31] ? 11'd0 : t_y[26:16];

    always_comb
    begin
        rsp_data_next.src_col     = in_src ? xx : 11'd0;
        rsp_data_next.src_row     = in_src ? yy : 11'd0;
        rsp_data_next.inside_res  = in_src;
        rsp_data_next.chroma_site = d_meta.chroma;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // An outside result carries a zero coordinate.
    `HPSM_ASSERT(a_outside_zero, rsp_valid_reg && !rsp_data_reg.inside_res |-> rsp_data_reg.src_col == 11'd0 && rsp_data_reg.src_row == 11'd0)
    // An item cleared for division has a nonzero divisor.
    `HPSM_ASSERT(a_div_den_nonzero, s3_valid_reg && (s3_meta_reg.ok_x || s3_meta_reg.ok_y) |-> s3_den_reg != '0)
    // A stall freezes the front of the pipeline.
    `HPSM_ASSERT(a_stall_holds, !en |=> $stable(s1_valid_reg) && $stable(s3_valid_reg))

endmodule

// ===== test/source_map_checker.sv =====
// Checker that predicts and compares the source pixel of every destination pixel.
`timescale 1ns / 1ps

module source_map_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_idx,
    input  logic [31:0] cfg_data,
    hpsm_stream_if      req,
    hpsm_stream_if      rsp,
    output int          mismatch_count,
    output int          pending_count
);

    localparam int SRC_W = 2048;
    localparam int SRC_H = 2048;
    localparam int DST_W = 4096;
    localparam int DST_H = 4096;
    localparam longint ONE_Q = 64'sd65536;
    localparam longint HALF_Q = 64'sd32768;

    // Local copy of the matrix, indexed by register number.
    longint         matrix [8];
    hpsm_pkg::rsp_t expected_pixels [$];

    // Maps one destination pixel to its expected source pixel.
    function automatic hpsm_pkg::rsp_t map_pixel(hpsm_pkg::req_t p);
        longint col;
        longint row;
        longint den;
        longint nx;
        longint ny;
        longint sx;
        longint sy;
        hpsm_pkg::rsp_t r;
        col = longint'(p.dst_col);
        row = longint'(p.dst_row);
        r = '0;
        r.chroma_site = !p.dst_col[0] && !p.dst_row[0];
        den = matrix[hpsm_pkg::REG_PERSP_X] * col + matrix[hpsm_pkg::REG_PERSP_Y] * row
              + ONE_Q;
        if (col < DST_W && row < DST_H && den > 0)
        begin
            nx = matrix[hpsm_pkg::REG_SCALE_XX] * col + matrix[hpsm_pkg::REG_SHEAR_XY] * row
                 + matrix[hpsm_pkg::REG_OFFSET_X];
            ny = matrix[hpsm_pkg::REG_SHEAR_YX] * col + matrix[hpsm_pkg::REG_SCALE_YY] * row
                 + matrix[hpsm_pkg::REG_OFFSET_Y];
            // Quotient keeps 16 fraction bits; then add one half and truncate.
            sx = ((nx * ONE_Q) / den + HALF_Q) / ONE_Q;
            sy = ((ny * ONE_Q) / den + HALF_Q) / ONE_Q;
            if (sx >= 0 && sx < SRC_W && sy >= 0 && sy < SRC_H)
            begin
                r.inside_res = 1'b1;
                r.src_col = sx[10:0];
                r.src_row = sy[10:0];
            end
        end
        return r;
    endfunction

    // Watch the three ports; a transaction is predicted with the matrix in force before any write.
    always @(posedge clk or negedge rst_n)
    begin
        hpsm_pkg::rsp_t got;
        hpsm_pkg::rsp_t want;
        if (!rst_n)
        begin
            matrix = '{65536, 0, 0, 0, 65536, 0, 0, 0};
            expected_pixels.delete();
            mismatch_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_pixels.push_back(map_pixel(req.data));
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: %p", got);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.src_col !== want.src_col || got.src_row !== want.src_row
                        || got.inside_res !== want.inside_res
                        || got.chroma_site !== want.chroma_site)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (cfg_we && cfg_idx <= hpsm_pkg::REG_PERSP_Y)
                matrix[cfg_idx] = longint'($signed(cfg_data));
            pending_count = expected_pixels.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench: stimulus, stall control, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [3:0] REG_UNMAPPED_LO = 4'd8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          mismatch_count;
    int          pending_count;
    int          quiet_cycles = 0;
    idle_mode_t  idle_mode;
    logic [31:0] matrix_words [8];

    hpsm_stream_if #(.payload_t(hpsm_pkg::req_t)) req_ch ();
    hpsm_stream_if #(.payload_t(hpsm_pkg::rsp_t)) rsp_ch ();

    homography_pixel_source_mapper_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    source_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random according to the current idling phase.
    always @(posedge clk)
    begin
        if (idle_mode == IDLE_RECEIVER)
            rsp_ch.ready <= ($urandom_range(99) >= 83);
        else if (idle_mode == IDLE_BOTH)
            rsp_ch.ready <= ($urandom_range(99) >= 37);
        else
            rsp_ch.ready <= 1'b1;
    end

    // Watchdog on cycles with no transaction on either channel and no register write.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one destination pixel, with random gaps before it in the idle phases.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        bit taken;
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 37 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= '{dst_col: col, dst_row: row};
        do
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Waits until every expected result has come, then lets the pipeline settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all matrix registers, plus one write to an unmapped index.
    task automatic load_matrix();
        drain();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= hpsm_pkg::reg_idx_t'(i);
            cfg_data <= matrix_words[i];
            @(posedge clk);
        end
        cfg_idx <= REG_UNMAPPED_LO + 4'($urandom_range(7));
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Picks a random matrix that mostly lands inside the source image.
    task automatic random_matrix();
        int sel;
        sel = $urandom_range(9);
        for (int i = 0; i < 8; i++)
            matrix_words[i] = $urandom;
        if (sel < 8)
        begin
            matrix_words[hpsm_pkg::REG_SCALE_XX] = $urandom_range(196608) - 65536;
            matrix_words[hpsm_pkg::REG_SHEAR_XY] = $urandom_range(65536) - 32768;
            matrix_words[hpsm_pkg::REG_OFFSET_X] = ($urandom_range(4096) - 2048) * 65536
                                                   + $urandom_range(65535);
            matrix_words[hpsm_pkg::REG_SHEAR_YX] = $urandom_range(65536) - 32768;
            matrix_words[hpsm_pkg::REG_SCALE_YY] = $urandom_range(196608) - 65536;
            matrix_words[hpsm_pkg::REG_OFFSET_Y] = ($urandom_range(4096) - 2048) * 65536
                                                   + $urandom_range(65535);
            matrix_words[hpsm_pkg::REG_PERSP_X] = (sel < 3) ? 0 : $urandom_range(64) - 32;
            matrix_words[hpsm_pkg::REG_PERSP_Y] = (sel < 3) ? 0 : $urandom_range(64) - 32;
        end
    endtask

    // Random pixels: mostly a local window, some across the full field.
    task automatic random_pixels(input int count);
        logic [11:0] c0;
        logic [11:0] r0;
        c0 = 12'($urandom);
        r0 = 12'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                send_pixel(12'($urandom), 12'($urandom));
            else
                send_pixel(c0 + 12'($urandom_range(63)), r0 + 12'($urandom_range(63)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = hpsm_pkg::REG_SCALE_XX;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        idle_mode = IDLE_NONE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix after reset: corners, parity cases, edge of the source.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd1, 12'd2);
        send_pixel(12'd2047, 12'd2047);
        send_pixel(12'd2048, 12'd2047);

        // Half scale with a half-pixel offset in x exercises rounding.
        matrix_words = '{32'h8000, 32'h0, 32'h8000, 32'h0, 32'h8000, 32'h0, 32'h0, 32'h0};
        load_matrix();
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd4094);
        send_pixel(12'd3, 12'd0);

        // Negative perspective: the divisor shrinks to a small positive value.
        matrix_words = '{32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
                         32'hFFFF_FFF0, 32'h0};
        load_matrix();
        send_pixel(12'd4095, 12'd5);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd4, 12'd0);

        // Register extremes, both signs.
        matrix_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_matrix();
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd4095);
        matrix_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
        load_matrix();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);

        // Random part over the idling phases, fresh matrix per block.
        for (int phase = 0; phase < 20; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            random_matrix();
            load_matrix();
            random_pixels(75);
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
